>>> sv/i2cmrw_pkg.sv
// Shared types and constants for the I2C master register write block.
package i2cmrw_pkg;

	// Register selector codes carried in the request.
	localparam logic [2:0] REG_CONTROL = 3'd0;
	localparam logic [2:0] REG_STATUS  = 3'd1;
	localparam logic [2:0] REG_SADDR   = 3'd2;
	localparam logic [2:0] REG_DATA    = 3'd3;

	// Bus action codes.
	localparam logic [1:0] OP_NONE  = 2'd0;
	localparam logic [1:0] OP_START = 2'd1;
	localparam logic [1:0] OP_SEND  = 2'd2;
	localparam logic [1:0] OP_RECV  = 2'd3;

	localparam logic [15:0] CTRL_MASK  = 16'hfff7;
	localparam logic [10:0] STAT_CLEAR = 11'h7f0;

	// Control register bit positions.
	localparam int CTRL_START = 0;
	localparam int CTRL_STOP  = 1;
	localparam int CTRL_NACK  = 2;
	localparam int CTRL_TB    = 3;
	localparam int CTRL_MA    = 4;
	localparam int CTRL_IUE   = 6;

	// Status register bit positions.
	localparam int ST_RWM = 0;
	localparam int ST_NAK = 1;
	localparam int ST_ITE = 6;
	localparam int ST_IRF = 7;
	localparam int ST_BED = 10;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [15:0] write_value;
		logic        bus_ack;
		logic [7:0]  bus_rx_byte;
	} req_t;

	typedef struct packed {
		logic [15:0] control;
		logic [10:0] status;
		logic [7:0]  data;
	} regs_t;

	typedef struct packed {
		logic [1:0]  bus_op;
		logic [7:0]  bus_byte;
		logic        bus_nack;
		logic        bus_stop;
		logic        slave_addr_write;
		logic [6:0]  slave_addr;
	} bus_res_t;

endpackage

>>> sv/i2cmrw_exec.sv
// Decode of one register write: next register contents and the bus action.
module i2cmrw_exec
	import i2cmrw_pkg::*;
(
	input  req_t     req,
	input  regs_t    regs,
	output regs_t    regs_next,
	output bus_res_t res
);

	logic [15:0] v;
	logic        xfer;
	logic        start;
	logic        recv;
	logic        ack;
	logic [10:0] st;

	assign v = req.write_value;

	always_comb begin
		regs_next = regs;
		res       = '0;
		xfer      = v[CTRL_TB] && v[CTRL_IUE];
		start     = v[CTRL_START];
		recv      = 1'b0;
		ack       = 1'b0;
		st        = regs.status;
		unique case (req.req_type)
			REG_CONTROL: begin
				regs_next.control = v & CTRL_MASK;
				if (xfer) begin
					if (start) begin
						st[ST_RWM]   = regs.data[0];
						res.bus_op   = OP_START;
						res.bus_byte = regs.data;
						ack          = req.bus_ack;
					end else if (regs.status[ST_RWM]) begin
						// A received byte always counts as acknowledged.
						recv           = 1'b1;
						regs_next.data = req.bus_rx_byte;
						res.bus_op     = OP_RECV;
						res.bus_nack   = v[CTRL_NACK];
						ack            = 1'b1;
					end else begin
						res.bus_op   = OP_SEND;
						res.bus_byte = regs.data;
						ack          = req.bus_ack;
					end
					res.bus_stop = v[CTRL_STOP];
					if (ack) begin
						if (recv) begin
							st[ST_IRF] = 1'b1;
						end else begin
							st[ST_ITE] = 1'b1;
						end
						st[ST_NAK] = 1'b0;
					end else begin
						st[ST_ITE] = 1'b1;
						st[ST_BED] = 1'b1;
						st[ST_NAK] = 1'b1;
					end
				end else if (!v[CTRL_TB] && v[CTRL_IUE] && v[CTRL_MA]) begin
					res.bus_stop = 1'b1;
				end
			end
			REG_STATUS: begin
				st = regs.status & ~(v[10:0] & STAT_CLEAR);
			end
			REG_SADDR: begin
				res.slave_addr_write = 1'b1;
				res.slave_addr       = v[6:0];
			end
			REG_DATA: begin
				regs_next.data = v[7:0];
			end
			default: begin
			end
		endcase
		regs_next.status = st;
	end

endmodule

>>> sv/i2c_master_register_write.sv
// Top level of the I2C master register write block.
// Each request is one register write; the block answers every request with exactly one
// result that reports the bus action taken and the register contents after the write.
// One request is taken per clock cycle, sustained, while the consumer takes results. A
// request is accepted into the input register, where the register file is read and
// updated, and its result then sits in the result register until the consumer takes it.
// The request register also serves as a skid stage, so one new request is taken while a
// finished result waits for the consumer.
module i2c_master_register_write
	import i2cmrw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// s_tdata: write_value [15:0], bus_ack [16], bus_rx_byte [24:17], zero [31:25]
	input  logic [31:0] s_tdata,
	// s_tuser: req_type [2:0]
	input  logic [2:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// m_tdata: bus_op [1:0], bus_byte [9:2], bus_nack [10], bus_stop [11],
	// slave_addr_write [12], slave_addr [19:13], status_now [30:20],
	// data_now [38:31], control_now [54:39], zero [55]
	output logic [55:0] m_tdata
);

	logic     valid_s1;
	req_t     req_s1;
	logic     advance;
	regs_t    regs_q;
	regs_t    regs_next;
	bus_res_t bus_res;
	bus_res_t res_s2;
	regs_t    regs_s2;
	logic     valid_s2;

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_s1.req_type    <= s_tuser;
			req_s1.write_value <= s_tdata[15:0];
			req_s1.bus_ack     <= s_tdata[16];
			req_s1.bus_rx_byte <= s_tdata[24:17];
		end
	end

	i2cmrw_exec u_exec (
		.req       (req_s1),
		.regs      (regs_q),
		.regs_next (regs_next),
		.res       (bus_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '0;
		end else if (advance) begin
			regs_q <= regs_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2  <= bus_res;
			regs_s2 <= regs_next;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {1'b0, regs_s2.control, regs_s2.data, regs_s2.status,
		res_s2.slave_addr, res_s2.slave_addr_write, res_s2.bus_stop,
		res_s2.bus_nack, res_s2.bus_byte, res_s2.bus_op};

`ifndef SYNTHESIS
	// A request that leaves the input register always produces a result.
	a_adv_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_tvalid)
		else $error("result missing after request advanced");

	// Registers change only when a request is processed.
	a_regs_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(regs_q))
		else $error("register file changed without a request");

	// A write to an unknown register leaves the registers untouched.
	a_unknown: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && req_s1.req_type != REG_CONTROL && req_s1.req_type != REG_STATUS &&
		req_s1.req_type != REG_SADDR && req_s1.req_type != REG_DATA) |=> $stable(regs_q))
		else $error("unknown register write changed state");

	// Only the mode, nack, empty, full and error status bits can ever be set.
	a_status_bits: assert property (@(posedge clk) disable iff (!arst_n)
		regs_q.status[5:2] == 4'd0 && regs_q.status[9:8] == 2'd0)
		else $error("reserved status bit set");

	// With no bus action, the byte and nack fields are zero.
	a_idle_bus: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.bus_op == OP_NONE) |-> (res_s2.bus_byte == 8'd0 && !res_s2.bus_nack))
		else $error("bus fields set without a bus action");
`endif

endmodule

>>> tb/tb_i2c_master_register_write.sv
// Self-checking testbench for the I2C master register write block.
`timescale 1ns / 1ps

module tb_i2c_master_register_write;
	import i2cmrw_pkg::*;

	// Selector values outside the four decoded registers.
	localparam logic [2:0] REG_UNKNOWN_FIRST = 3'd4;
	localparam logic [2:0] REG_UNKNOWN_LAST  = 3'd7;

	localparam int RESULT_LATENCY = 2;
	localparam int HOLD_CYCLES    = 80;
	localparam int IDLE_PERCENT   = 26;
	localparam int CYCLE_LIMIT    = 200000;
	localparam int PRINT_LIMIT    = 40;

	typedef struct packed {
		bus_res_t bus;
		regs_t    regs;
	} write_outcome_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic [2:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;

	// Shadow copy of the register file, updated as requests are accepted.
	regs_t          shadow_regs;
	write_outcome_t outcome_q[$];

	int  error_count;
	int  cycle_count;
	int  writes_sent;
	int  results_checked;
	int  starts_seen, sends_seen, receives_seen, stops_seen;
	bit  idle_on;
	int  hold_req_count;
	int  hold_done_count;
	int  hold_left;

	i2c_master_register_write uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding.",
				cycle_count, outcome_q.size());
			$display("FAIL");
			$finish;
		end
	end

	task automatic report_error(input string msg);
		error_count++;
		if (error_count <= PRINT_LIMIT)
			$display("[%0t] ERROR: %s", $realtime, msg);
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
		input logic [15:0] want);
		if (got !== want)
			report_error($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
				results_checked, name, got, want));
	endtask

	// Applies one register write to the shadow registers and returns what the
	// block should report for it.
	function automatic write_outcome_t predict_reg_write(input logic [2:0] sel,
		input logic [15:0] value, input logic partner_ack, input logic [7:0] rx);
		write_outcome_t r;
		logic           is_start;
		logic           acked;
		r = '0;
		case (sel)
			REG_CONTROL: begin
				shadow_regs.control = value & CTRL_MASK;
				if (value[CTRL_TB] && value[CTRL_IUE]) begin
					is_start = value[CTRL_START];
					if (is_start) begin
						shadow_regs.status[ST_RWM] = shadow_regs.data[0];
						r.bus.bus_op = OP_START;
						r.bus.bus_byte = shadow_regs.data;
						acked = partner_ack;
					end else if (shadow_regs.status[ST_RWM]) begin
						// A received byte always counts as acknowledged.
						shadow_regs.data = rx;
						r.bus.bus_op = OP_RECV;
						r.bus.bus_nack = value[CTRL_NACK];
						acked = 1'b1;
					end else begin
						r.bus.bus_op = OP_SEND;
						r.bus.bus_byte = shadow_regs.data;
						acked = partner_ack;
					end
					r.bus.bus_stop = value[CTRL_STOP];
					if (acked) begin
						if (r.bus.bus_op == OP_RECV)
							shadow_regs.status[ST_IRF] = 1'b1;
						else
							shadow_regs.status[ST_ITE] = 1'b1;
						shadow_regs.status[ST_NAK] = 1'b0;
					end else begin
						shadow_regs.status[ST_ITE] = 1'b1;
						shadow_regs.status[ST_BED] = 1'b1;
						shadow_regs.status[ST_NAK] = 1'b1;
					end
				end else if (!value[CTRL_TB] && value[CTRL_IUE] && value[CTRL_MA]) begin
					r.bus.bus_stop = 1'b1;
				end
			end
			REG_STATUS: shadow_regs.status = shadow_regs.status & ~(value[10:0] & STAT_CLEAR);
			REG_SADDR: begin
				r.bus.slave_addr_write = 1'b1;
				r.bus.slave_addr = value[6:0];
			end
			REG_DATA: shadow_regs.data = value[7:0];
			default: ;
		endcase
		r.regs = shadow_regs;
		return r;
	endfunction

	// Predicts accepted requests and checks accepted results.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (outcome_q.size() == 0) begin
				report_error($sformatf("result with no request pending: 0x%0h", m_tdata));
			end else begin
				write_outcome_t want;
				want = outcome_q.pop_front();
				check_field("bus_op", 16'(m_tdata[1:0]), 16'(want.bus.bus_op));
				check_field("bus_byte", 16'(m_tdata[9:2]), 16'(want.bus.bus_byte));
				check_field("bus_nack", 16'(m_tdata[10]), 16'(want.bus.bus_nack));
				check_field("bus_stop", 16'(m_tdata[11]), 16'(want.bus.bus_stop));
				check_field("slave_addr_write", 16'(m_tdata[12]),
					16'(want.bus.slave_addr_write));
				check_field("slave_addr", 16'(m_tdata[19:13]), 16'(want.bus.slave_addr));
				check_field("status_now", 16'(m_tdata[30:20]), 16'(want.regs.status));
				check_field("data_now", 16'(m_tdata[38:31]), 16'(want.regs.data));
				check_field("control_now", m_tdata[54:39], want.regs.control);
				check_field("pad", 16'(m_tdata[55]), 16'd0);
				results_checked++;
			end
		end
		if (arst_n && s_tvalid && s_tready) begin
			write_outcome_t pred;
			pred = predict_reg_write(s_tuser, s_tdata[15:0], s_tdata[16], s_tdata[24:17]);
			case (pred.bus.bus_op)
				OP_START: starts_seen++;
				OP_SEND:  sends_seen++;
				OP_RECV:  receives_seen++;
				default: ;
			endcase
			if (pred.bus.bus_stop)
				stops_seen++;
			outcome_q.push_back(pred);
		end
	end

	// Result consumer: random stalls, plus a long hold-off when one is requested.
	always @(negedge clk) begin
		if (hold_done_count != hold_req_count) begin
			hold_done_count = hold_req_count;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= !(idle_on && $urandom_range(99) < IDLE_PERCENT);
		end
	end

	// Offers one request and returns at the falling edge after it is taken.
	task automatic write_reg(input logic [2:0] sel, input logic [15:0] value,
		input logic partner_ack, input logic [7:0] rx);
		while (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= sel;
		s_tdata  <= {7'b0, rx, partner_ack, value};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		writes_sent++;
		@(negedge clk);
	endtask

	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		while (outcome_q.size() != 0)
			@(negedge clk);
	endtask

	function automatic logic [15:0] xfer_ctrl(input logic start, input logic stop,
		input logic nack);
		logic [15:0] v;
		v = '0;
		v[CTRL_TB]    = 1'b1;
		v[CTRL_IUE]   = 1'b1;
		v[CTRL_START] = start;
		v[CTRL_STOP]  = stop;
		v[CTRL_NACK]  = nack;
		return v;
	endfunction

	// A well-formed transfer: address, start, a few byte transfers, stop on the last.
	task automatic send_transfer();
		logic [7:0]  addr;
		logic [15:0] noise;
		int          n_bytes;
		addr = 8'($urandom);
		n_bytes = $urandom_range(1, 4);
		write_reg(REG_DATA, {8'($urandom), addr}, 1'($urandom), 8'($urandom));
		noise = 16'($urandom);
		write_reg(REG_CONTROL, noise | xfer_ctrl(1'b1, 1'b0, 1'b0),
			$urandom_range(99) < 85, 8'($urandom));
		for (int i = 0; i < n_bytes; i++) begin
			if (!addr[0])
				write_reg(REG_DATA, 16'($urandom), 1'($urandom), 8'($urandom));
			noise = 16'($urandom);
			noise[CTRL_START] = 1'b0;
			noise[CTRL_STOP]  = (i == n_bytes - 1);
			write_reg(REG_CONTROL, noise | xfer_ctrl(1'b0, i == n_bytes - 1, 1'($urandom)),
				$urandom_range(99) < 85, 8'($urandom));
		end
		if ($urandom_range(3) == 0)
			write_reg(REG_STATUS, 16'($urandom), 1'($urandom), 8'($urandom));
		if ($urandom_range(5) == 0)
			write_reg(REG_SADDR, 16'($urandom), 1'($urandom), 8'($urandom));
	endtask

	task automatic test_directed();
		write_reg(REG_UNKNOWN_FIRST, 16'hffff, 1'b1, 8'hff);
		write_reg(REG_CONTROL, 16'h0000, 1'b0, 8'h00);
		write_reg(REG_CONTROL, 16'h0008, 1'b1, 8'h00);
		// Send with the partner acknowledging, then without.
		write_reg(REG_CONTROL, xfer_ctrl(1'b0, 1'b0, 1'b0), 1'b1, 8'h3c);
		write_reg(REG_CONTROL, xfer_ctrl(1'b0, 1'b0, 1'b0), 1'b0, 8'h3c);
		write_reg(REG_STATUS, 16'hffff, 1'b0, 8'h00);
		write_reg(REG_DATA, 16'hffff, 1'b0, 8'h00);
		// Start with the read bit set switches the following transfers to receive.
		write_reg(REG_CONTROL, xfer_ctrl(1'b1, 1'b0, 1'b0), 1'b1, 8'h00);
		write_reg(REG_CONTROL, xfer_ctrl(1'b0, 1'b1, 1'b1), 1'b0, 8'ha5);
		write_reg(REG_CONTROL, xfer_ctrl(1'b0, 1'b0, 1'b0), 1'b1, 8'h00);
		write_reg(REG_CONTROL, xfer_ctrl(1'b0, 1'b0, 1'b1), 1'b1, 8'hff);
		write_reg(REG_CONTROL, 16'h0050, 1'b1, 8'h00);
		write_reg(REG_CONTROL, 16'h0058, 1'b0, 8'h5a);
		write_reg(REG_DATA, 16'h0000, 1'b1, 8'h00);
		write_reg(REG_CONTROL, xfer_ctrl(1'b1, 1'b0, 1'b0), 1'b0, 8'h00);
		write_reg(REG_CONTROL, xfer_ctrl(1'b0, 1'b1, 1'b0), 1'b1, 8'h00);
		write_reg(REG_SADDR, 16'hffff, 1'b1, 8'hff);
		write_reg(REG_SADDR, 16'h0000, 1'b0, 8'h00);
		write_reg(REG_SADDR, 16'h0055, 1'b0, 8'h00);
		write_reg(REG_STATUS, 16'h0040, 1'b0, 8'h00);
		write_reg(REG_CONTROL, 16'hffff, 1'b1, 8'h00);
		write_reg(REG_UNKNOWN_LAST, 16'hffff, 1'b1, 8'hff);
		write_reg(REG_DATA, 16'h0100, 1'b1, 8'h00);
		wait_for_results();
	endtask

	task automatic test_transfers(input int n_writes);
		int target;
		target = writes_sent + n_writes;
		while (writes_sent < target)
			send_transfer();
	endtask

	task automatic test_back_pressure();
		idle_on = 1'b0;
		hold_req_count++;
		test_transfers(40);
		idle_on = 1'b1;
		wait_for_results();
	endtask

	task automatic test_no_idle();
		idle_on = 1'b0;
		test_transfers(150);
		idle_on = 1'b1;
	endtask

	task automatic test_register_noise(input int n_writes);
		logic [2:0] sel;
		repeat (n_writes) begin
			sel = 3'($urandom_range(7));
			write_reg(sel, 16'($urandom), 1'($urandom), 8'($urandom));
		end
	endtask

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		idle_on  = 1'b1;
		shadow_regs = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_transfers(330);
		test_back_pressure();
		test_no_idle();
		test_register_noise(120);
		test_transfers(150);

		wait_for_results();
		repeat (RESULT_LATENCY + 4) @(negedge clk);
		if (outcome_q.size() != 0)
			report_error($sformatf("%0d results never arrived", outcome_q.size()));

		$display("Checked %0d of %0d register writes: %0d starts, %0d sends,",
			results_checked, writes_sent, starts_seen, sends_seen);
		$display("%0d receives, %0d stops, a %0d-cycle consumer hold-off and random noise.",
			receives_seen, stops_seen, HOLD_CYCLES);
		if (error_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
